@@ hw/rtl/sqcg_pkg.sv @@
// Shared widths, register codes and types of the surface quad corner generator.
package sqcg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int NORM_W    = FRAC_BITS + 2;
    localparam int REG_W     = FRAC_BITS + 1;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int VX_W      = REG_W + 1;
    localparam int PROD_W    = VX_W + NORM_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int RS_W      = (CROSS_W > EDGE_W) ? CROSS_W : EDGE_W;
    localparam int MAG_W     = RS_W;
    localparam int POS_W     = $clog2(MAG_W);
    localparam int MAN_W     = 30;
    localparam int MAN_TOP   = MAN_W - 1;
    localparam int SQR_W     = 2 * MAN_W;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = MAN_W + 1;
    localparam int SQRT_D    = ROOT_W;
    localparam int NUM_W     = MAN_W + REG_W + 1;
    localparam int QUO_W     = REG_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int LPROD_W   = NORM_W + REG_W;
    localparam int LIFT_W    = NORM_W + REG_W - FRAC_BITS + 1;
    localparam int SUM_W     = COORD_W + 3;
    localparam int RS_D      = 5 + SQRT_D + 1 + QUO_W + 1;
    localparam int CROSS_D   = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIFT = 1'd1;
    localparam logic [REG_W-1:0]     HALF_SIZE_RST   = REG_W'(6554);
    localparam logic [REG_W-1:0]     NORMAL_LIFT_RST = REG_W'(66);

    typedef logic [2:0][COORD_W-1:0] t_coord3;

    typedef struct packed {
        t_coord3                   c;
        logic [2:0][LIFT_W-1:0]    lf;
        logic [2:0][NORM_W-1:0]    n;
        logic [2:0][VX_W-1:0]      vx;
        logic                      degen;
    } t_side;

endpackage

@@ hw/rtl/sqcg_face_if.sv @@
// Input channel carrying one face word.
interface sqcg_face_if;
    logic                                valid;
    logic                                ready;
    logic signed [sqcg_pkg::COORD_W-1:0] first_vertex_x;
    logic signed [sqcg_pkg::COORD_W-1:0] first_vertex_y;
    logic signed [sqcg_pkg::COORD_W-1:0] first_vertex_z;
    logic signed [sqcg_pkg::COORD_W-1:0] second_vertex_x;
    logic signed [sqcg_pkg::COORD_W-1:0] second_vertex_y;
    logic signed [sqcg_pkg::COORD_W-1:0] second_vertex_z;
    logic signed [sqcg_pkg::NORM_W-1:0]  normal_x;
    logic signed [sqcg_pkg::NORM_W-1:0]  normal_y;
    logic signed [sqcg_pkg::NORM_W-1:0]  normal_z;
    logic signed [sqcg_pkg::COORD_W-1:0] centre_x;
    logic signed [sqcg_pkg::COORD_W-1:0] centre_y;
    logic signed [sqcg_pkg::COORD_W-1:0] centre_z;

    modport source (
        output valid, first_vertex_x, first_vertex_y, first_vertex_z,
               second_vertex_x, second_vertex_y, second_vertex_z,
               normal_x, normal_y, normal_z, centre_x, centre_y, centre_z,
        input  ready
    );
    modport sink (
        input  valid, first_vertex_x, first_vertex_y, first_vertex_z,
               second_vertex_x, second_vertex_y, second_vertex_z,
               normal_x, normal_y, normal_z, centre_x, centre_y, centre_z,
        output ready
    );
endinterface

@@ hw/rtl/sqcg_corner_if.sv @@
// Output channel carrying one corner word.
interface sqcg_corner_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          corner_index;
    logic signed [sqcg_pkg::COORD_W-1:0] corner_x;
    logic signed [sqcg_pkg::COORD_W-1:0] corner_y;
    logic signed [sqcg_pkg::COORD_W-1:0] corner_z;
    logic                                degenerate;
    logic                                last_corner;

    modport source (
        output valid, corner_index, corner_x, corner_y, corner_z, degenerate, last_corner,
        input  ready
    );
    modport sink (
        input  valid, corner_index, corner_x, corner_y, corner_z, degenerate, last_corner,
        output ready
    );
endinterface

@@ hw/rtl/sqcg_front.sv @@
// Front stages: edge vector and rounded lift along the normal.
module sqcg_front (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_vld,
    input  sqcg_pkg::t_coord3                            i_v0,
    input  sqcg_pkg::t_coord3                            i_v1,
    input  logic [2:0][sqcg_pkg::NORM_W-1:0]             i_n,
    input  sqcg_pkg::t_coord3                            i_c,
    input  logic [sqcg_pkg::REG_W-1:0]                   i_lift,
    output logic                                         o_vld,
    output logic [2:0][sqcg_pkg::RS_W-1:0]               o_vec,
    output sqcg_pkg::t_side                              o_sb
);

    logic [2:0][sqcg_pkg::EDGE_W-1:0]  r_e;
    logic [2:0][sqcg_pkg::LPROD_W-1:0] r_lp;
    logic [2:0]                        r_ns;
    logic [2:0][sqcg_pkg::NORM_W-1:0]  r_n;
    sqcg_pkg::t_coord3                 r_c;
    logic                              r_v0;
    logic                              r_v1;
    logic [2:0][sqcg_pkg::RS_W-1:0]    r_vec;
    sqcg_pkg::t_side                   r_sb;

    logic [2:0][sqcg_pkg::NORM_W-1:0]  nm;
    logic [2:0][sqcg_pkg::EDGE_W-1:0]  n_e;
    logic [2:0][sqcg_pkg::LPROD_W:0]   rq;
    logic [2:0][sqcg_pkg::LIFT_W-1:0]  n_lf;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nm[i]  = i_n[i][sqcg_pkg::NORM_W-1] ? (~i_n[i] + 1'b1) : i_n[i];
            n_e[i] = {i_v1[i][sqcg_pkg::COORD_W-1], i_v1[i]}
                   - {i_v0[i][sqcg_pkg::COORD_W-1], i_v0[i]};
            rq[i]  = ((sqcg_pkg::LPROD_W+1)'(r_lp[i])
                   + ((sqcg_pkg::LPROD_W+1)'(1) << (sqcg_pkg::FRAC_BITS - 1)))
                   >> sqcg_pkg::FRAC_BITS;
            n_lf[i] = r_ns[i] ? (~rq[i][sqcg_pkg::LIFT_W-1:0] + 1'b1)
                              : rq[i][sqcg_pkg::LIFT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i]   <= n_e[i];
                r_lp[i]  <= sqcg_pkg::LPROD_W'(nm[i]) * sqcg_pkg::LPROD_W'(i_lift);
                r_ns[i]  <= i_n[i][sqcg_pkg::NORM_W-1];
                r_vec[i] <= sqcg_pkg::RS_W'($signed(r_e[i]));
            end
            r_n         <= i_n;
            r_c         <= i_c;
            r_sb.c      <= r_c;
            r_sb.n      <= r_n;
            r_sb.lf     <= n_lf;
            r_sb.vx     <= '0;
            r_sb.degen  <= 1'b0;
        end
    end

    assign o_vld = r_v1;
    assign o_vec = r_vec;
    assign o_sb  = r_sb;

endmodule

@@ hw/rtl/sqcg_rescale.sv @@
// Vector rescale pipeline: normalize, square root and divide, one bit a stage.
module sqcg_rescale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [2:0][sqcg_pkg::RS_W-1:0]       i_vec,
    input  logic [sqcg_pkg::REG_W-1:0]           i_size,
    input  sqcg_pkg::t_side                      i_sb,
    output logic                                 o_vld,
    output logic [2:0][sqcg_pkg::VX_W-1:0]       o_res,
    output logic                                 o_zero,
    output sqcg_pkg::t_side                      o_sb
);

    localparam int LAST_Q = sqcg_pkg::SQRT_D - 1;
    localparam int LAST_D = sqcg_pkg::QUO_W - 1;

    logic                  r_v  [sqcg_pkg::RS_D];
    sqcg_pkg::t_side       r_sb [sqcg_pkg::RS_D];

    logic [2:0][sqcg_pkg::MAG_W-1:0] mag;
    logic [sqcg_pkg::MAG_W-1:0]      mx;
    logic [2:0][sqcg_pkg::MAG_W-1:0] r_mag0;
    logic [2:0]                      r_s0;
    logic [sqcg_pkg::MAG_W-1:0]      r_mx0;

    logic [sqcg_pkg::POS_W-1:0]      pos;
    logic [2:0][sqcg_pkg::MAG_W-1:0] r_mag1;
    logic [2:0]                      r_s1;
    logic [sqcg_pkg::POS_W-1:0]      r_pos1;
    logic                            r_z1;

    logic [2:0][sqcg_pkg::MAG_W-1:0] sh;
    logic [2:0][sqcg_pkg::MAN_W-1:0] r_m2;
    logic [2:0]                      r_s2;
    logic                            r_z2;

    logic [2:0][sqcg_pkg::SQR_W-1:0] r_sq3;
    logic [2:0][sqcg_pkg::MAN_W-1:0] r_m3;
    logic [2:0]                      r_s3;
    logic                            r_z3;

    logic [sqcg_pkg::SQ_W-1:0]       r_sum4;
    logic [2:0][sqcg_pkg::MAN_W-1:0] r_m4;
    logic [2:0]                      r_s4;
    logic                            r_z4;

    logic [sqcg_pkg::SQ_W-1:0]       r_qx [sqcg_pkg::SQRT_D];
    logic [sqcg_pkg::SQ_W-1:0]       r_qr [sqcg_pkg::SQRT_D];
    logic [2:0][sqcg_pkg::MAN_W-1:0] r_qm [sqcg_pkg::SQRT_D];
    logic [2:0]                      r_qs [sqcg_pkg::SQRT_D];
    logic                            r_qz [sqcg_pkg::SQRT_D];
    logic [sqcg_pkg::SQ_W-1:0]       qxi  [sqcg_pkg::SQRT_D];
    logic [sqcg_pkg::SQ_W-1:0]       qri  [sqcg_pkg::SQRT_D];
    logic [sqcg_pkg::SQ_W-1:0]       n_qx [sqcg_pkg::SQRT_D];
    logic [sqcg_pkg::SQ_W-1:0]       n_qr [sqcg_pkg::SQRT_D];
    logic [sqcg_pkg::SQ_W-1:0]       bitc [sqcg_pkg::SQRT_D];

    logic [sqcg_pkg::ROOT_W-1:0]     len;
    logic [2:0][sqcg_pkg::NUM_W-1:0] r_num5;
    logic [sqcg_pkg::ROOT_W-1:0]     r_l5;
    logic [2:0]                      r_s5;
    logic                            r_z5;

    logic [2:0][sqcg_pkg::REM_W-1:0] r_dr [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::QUO_W-1:0] r_dq [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::NUM_W-1:0] r_dn [sqcg_pkg::QUO_W];
    logic [sqcg_pkg::ROOT_W-1:0]     r_dl [sqcg_pkg::QUO_W];
    logic [2:0]                      r_ds [sqcg_pkg::QUO_W];
    logic                            r_dz [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::REM_W-1:0] dri  [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::QUO_W-1:0] dqi  [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::NUM_W-1:0] dni  [sqcg_pkg::QUO_W];
    logic [sqcg_pkg::ROOT_W-1:0]     dli  [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::REM_W-1:0] n_dr [sqcg_pkg::QUO_W];
    logic [2:0][sqcg_pkg::QUO_W-1:0] n_dq [sqcg_pkg::QUO_W];
    logic [sqcg_pkg::REM_W-1:0]      trial[sqcg_pkg::QUO_W][3];

    logic [2:0][sqcg_pkg::VX_W-1:0]  qext;
    logic [2:0][sqcg_pkg::VX_W-1:0]  r_res;
    logic                            r_zo;

    always_comb begin
        mx = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = i_vec[i][sqcg_pkg::RS_W-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
            if (mag[i] > mx) begin
                mx = mag[i];
            end
        end
        pos = '0;
        for (int b = 0; b < sqcg_pkg::MAG_W; b++) begin
            if (r_mx0[b]) begin
                pos = sqcg_pkg::POS_W'(b);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r_pos1 >= sqcg_pkg::POS_W'(sqcg_pkg::MAN_TOP)) begin
                sh[i] = r_mag1[i] >> (r_pos1 - sqcg_pkg::POS_W'(sqcg_pkg::MAN_TOP));
            end else begin
                sh[i] = r_mag1[i] << (sqcg_pkg::POS_W'(sqcg_pkg::MAN_TOP) - r_pos1);
            end
        end
    end

    always_comb begin
        qxi[0] = r_sum4;
        qri[0] = '0;
        for (int k = 1; k < sqcg_pkg::SQRT_D; k++) begin
            qxi[k] = r_qx[k-1];
            qri[k] = r_qr[k-1];
        end
        for (int k = 0; k < sqcg_pkg::SQRT_D; k++) begin
            bitc[k] = sqcg_pkg::SQ_W'(1) << (2 * (sqcg_pkg::SQRT_D - 1 - k));
            if (qxi[k] >= qri[k] + bitc[k]) begin
                n_qx[k] = qxi[k] - (qri[k] + bitc[k]);
                n_qr[k] = (qri[k] >> 1) + bitc[k];
            end else begin
                n_qx[k] = qxi[k];
                n_qr[k] = qri[k] >> 1;
            end
        end
    end

    assign len = r_qr[LAST_Q][sqcg_pkg::ROOT_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dri[0][i] = sqcg_pkg::REM_W'(r_num5[i][sqcg_pkg::NUM_W-1:sqcg_pkg::QUO_W]);
        end
        dqi[0] = '0;
        dni[0] = r_num5;
        dli[0] = r_l5;
        for (int j = 1; j < sqcg_pkg::QUO_W; j++) begin
            dri[j] = r_dr[j-1];
            dqi[j] = r_dq[j-1];
            dni[j] = r_dn[j-1];
            dli[j] = r_dl[j-1];
        end
        for (int j = 0; j < sqcg_pkg::QUO_W; j++) begin
            for (int i = 0; i < 3; i++) begin
                trial[j][i] = {dri[j][i][sqcg_pkg::REM_W-2:0],
                               dni[j][i][sqcg_pkg::QUO_W-1-j]};
                if (trial[j][i] >= sqcg_pkg::REM_W'(dli[j])) begin
                    n_dr[j][i] = trial[j][i] - sqcg_pkg::REM_W'(dli[j]);
                    n_dq[j][i] = {dqi[j][i][sqcg_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_dr[j][i] = trial[j][i];
                    n_dq[j][i] = {dqi[j][i][sqcg_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            qext[i] = {1'b0, r_dq[LAST_D][i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < sqcg_pkg::RS_D; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_vld;
            for (int s = 1; s < sqcg_pkg::RS_D; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            for (int s = 1; s < sqcg_pkg::RS_D; s++) begin
                r_sb[s] <= r_sb[s-1];
            end

            r_mag0 <= mag;
            r_mx0  <= mx;
            for (int i = 0; i < 3; i++) begin
                r_s0[i] <= i_vec[i][sqcg_pkg::RS_W-1];
            end

            r_mag1 <= r_mag0;
            r_s1   <= r_s0;
            r_pos1 <= pos;
            r_z1   <= (r_mx0 == '0);

            for (int i = 0; i < 3; i++) begin
                r_m2[i]  <= sh[i][sqcg_pkg::MAN_W-1:0];
                r_sq3[i] <= sqcg_pkg::SQR_W'(r_m2[i]) * sqcg_pkg::SQR_W'(r_m2[i]);
            end
            r_s2 <= r_s1;
            r_z2 <= r_z1;
            r_m3 <= r_m2;
            r_s3 <= r_s2;
            r_z3 <= r_z2;

            r_sum4 <= sqcg_pkg::SQ_W'(r_sq3[0]) + sqcg_pkg::SQ_W'(r_sq3[1])
                    + sqcg_pkg::SQ_W'(r_sq3[2]);
            r_m4 <= r_m3;
            r_s4 <= r_s3;
            r_z4 <= r_z3;

            for (int k = 0; k < sqcg_pkg::SQRT_D; k++) begin
                r_qx[k] <= n_qx[k];
                r_qr[k] <= n_qr[k];
            end
            r_qm[0] <= r_m4;
            r_qs[0] <= r_s4;
            r_qz[0] <= r_z4;
            for (int k = 1; k < sqcg_pkg::SQRT_D; k++) begin
                r_qm[k] <= r_qm[k-1];
                r_qs[k] <= r_qs[k-1];
                r_qz[k] <= r_qz[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_num5[i] <= sqcg_pkg::NUM_W'(r_qm[LAST_Q][i]) * sqcg_pkg::NUM_W'(i_size)
                           + sqcg_pkg::NUM_W'(len >> 1);
            end
            r_l5 <= len;
            r_s5 <= r_qs[LAST_Q];
            r_z5 <= r_qz[LAST_Q];

            for (int j = 0; j < sqcg_pkg::QUO_W; j++) begin
                r_dr[j] <= n_dr[j];
                r_dq[j] <= n_dq[j];
                r_dn[j] <= dni[j];
                r_dl[j] <= dli[j];
            end
            r_ds[0] <= r_s5;
            r_dz[0] <= r_z5;
            for (int j = 1; j < sqcg_pkg::QUO_W; j++) begin
                r_ds[j] <= r_ds[j-1];
                r_dz[j] <= r_dz[j-1];
            end

            for (int i = 0; i < 3; i++) begin
                if (r_dz[LAST_D]) begin
                    r_res[i] <= '0;
                end else if (r_ds[LAST_D][i]) begin
                    r_res[i] <= ~qext[i] + 1'b1;
                end else begin
                    r_res[i] <= qext[i];
                end
            end
            r_zo <= r_dz[LAST_D];
        end
    end

    assign o_vld  = r_v[sqcg_pkg::RS_D-1];
    assign o_sb   = r_sb[sqcg_pkg::RS_D-1];
    assign o_res  = r_res;
    assign o_zero = r_zo;

endmodule

@@ hw/rtl/sqcg_cross.sv @@
// Cross product of the scaled edge with the normal, two stages.
module sqcg_cross (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [2:0][sqcg_pkg::VX_W-1:0]       i_vx,
    input  logic                                 i_zero,
    input  sqcg_pkg::t_side                      i_sb,
    output logic                                 o_vld,
    output logic [2:0][sqcg_pkg::RS_W-1:0]       o_vec,
    output sqcg_pkg::t_side                      o_sb
);

    logic signed [sqcg_pkg::PROD_W-1:0] r_p [6];
    logic signed [sqcg_pkg::PROD_W-1:0] vxs [3];
    logic signed [sqcg_pkg::PROD_W-1:0] ns  [3];
    logic [2:0][sqcg_pkg::RS_W-1:0]     r_vec;
    sqcg_pkg::t_side                    n_sb;
    sqcg_pkg::t_side                    r_sb0;
    sqcg_pkg::t_side                    r_sb1;
    logic                               r_v0;
    logic                               r_v1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vxs[i] = sqcg_pkg::PROD_W'($signed(i_vx[i]));
            ns[i]  = sqcg_pkg::PROD_W'($signed(i_sb.n[i]));
        end
        n_sb       = i_sb;
        n_sb.vx    = i_vx;
        n_sb.degen = i_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= vxs[1] * ns[2];
            r_p[1] <= vxs[2] * ns[1];
            r_p[2] <= vxs[2] * ns[0];
            r_p[3] <= vxs[0] * ns[2];
            r_p[4] <= vxs[0] * ns[1];
            r_p[5] <= vxs[1] * ns[0];
            r_sb0    <= n_sb;
            r_vec[0] <= sqcg_pkg::RS_W'(sqcg_pkg::CROSS_W'(r_p[0]) - sqcg_pkg::CROSS_W'(r_p[1]));
            r_vec[1] <= sqcg_pkg::RS_W'(sqcg_pkg::CROSS_W'(r_p[2]) - sqcg_pkg::CROSS_W'(r_p[3]));
            r_vec[2] <= sqcg_pkg::RS_W'(sqcg_pkg::CROSS_W'(r_p[4]) - sqcg_pkg::CROSS_W'(r_p[5]));
            r_sb1 <= r_sb0;
        end
    end

    assign o_vld = r_v1;
    assign o_vec = r_vec;
    assign o_sb  = r_sb1;

endmodule

@@ hw/rtl/sqcg_emit.sv @@
// Corner sums with saturation and the four-word output register.
module sqcg_emit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic [2:0][sqcg_pkg::VX_W-1:0]       i_vy,
    input  logic                                 i_zero,
    input  sqcg_pkg::t_side                      i_sb,
    input  logic                                 i_ready,
    output logic                                 o_en,
    output logic                                 o_valid,
    output logic [1:0]                           o_index,
    output sqcg_pkg::t_coord3                    o_corner,
    output logic                                 o_degen,
    output logic                                 o_last
);

    localparam logic [1:0] LAST_IDX = 2'd3;

    sqcg_pkg::t_coord3               r_cor [4];
    sqcg_pkg::t_coord3               n_cor [4];
    logic                            r_full;
    logic [1:0]                      r_cnt;
    logic                            r_degen;
    logic signed [sqcg_pkg::SUM_W-1:0] d;
    logic signed [sqcg_pkg::SUM_W-1:0] s;
    logic                            fire;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                unique case (k)
                    0:       d =  sqcg_pkg::SUM_W'($signed(i_sb.vx[i]));
                    1:       d = -sqcg_pkg::SUM_W'($signed(i_vy[i]));
                    2:       d = -sqcg_pkg::SUM_W'($signed(i_sb.vx[i]));
                    default: d =  sqcg_pkg::SUM_W'($signed(i_vy[i]));
                endcase
                s = sqcg_pkg::SUM_W'($signed(i_sb.c[i])) + d
                  + sqcg_pkg::SUM_W'($signed(i_sb.lf[i]));
                if (s[sqcg_pkg::SUM_W-1:sqcg_pkg::COORD_W-1] == '0
                    || s[sqcg_pkg::SUM_W-1:sqcg_pkg::COORD_W-1] == '1) begin
                    n_cor[k][i] = s[sqcg_pkg::COORD_W-1:0];
                end else if (s[sqcg_pkg::SUM_W-1]) begin
                    n_cor[k][i] = {1'b1, {(sqcg_pkg::COORD_W-1){1'b0}}};
                end else begin
                    n_cor[k][i] = {1'b0, {(sqcg_pkg::COORD_W-1){1'b1}}};
                end
            end
        end
    end

    assign fire = r_full && i_ready;
    assign o_en = !r_full || (i_ready && (r_cnt == LAST_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (fire) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (o_en) begin
                r_full <= i_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            for (int k = 0; k < 4; k++) begin
                r_cor[k] <= n_cor[k];
            end
            r_degen <= i_sb.degen | i_zero;
        end
    end

    assign o_valid  = r_full;
    assign o_index  = r_cnt;
    assign o_corner = r_cor[r_cnt];
    assign o_degen  = r_degen;
    assign o_last   = (r_cnt == LAST_IDX);

endmodule

@@ hw/rtl/surface_quad_corner_generator_core.sv @@
// Top level of the surface quad corner generator.
// Latency: 115 register stages lie between an accepted word and its first valid corner.
// Throughput: four corners per input word, one corner per cycle while the receiver is ready;
// the four-corner output register paces the whole pipeline.
// Reset: synchronous, active low; clears all valid bits and loads half_size = 6554,
// normal_lift = 66.
module surface_quad_corner_generator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sqcg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sqcg_pkg::REG_W-1:0]            i_cfg_data,
    sqcg_face_if.sink                             i_face,
    sqcg_corner_if.source                         o_corner
);

    logic [sqcg_pkg::REG_W-1:0]      r_half_size;
    logic [sqcg_pkg::REG_W-1:0]      r_normal_lift;

    logic                            en;
    sqcg_pkg::t_coord3               v0;
    sqcg_pkg::t_coord3               v1;
    sqcg_pkg::t_coord3               cc;
    logic [2:0][sqcg_pkg::NORM_W-1:0] nn;

    logic                            f_vld;
    logic [2:0][sqcg_pkg::RS_W-1:0]  f_vec;
    sqcg_pkg::t_side                 f_sb;
    logic                            a_vld;
    logic [2:0][sqcg_pkg::VX_W-1:0]  a_res;
    logic                            a_zero;
    sqcg_pkg::t_side                 a_sb;
    logic                            x_vld;
    logic [2:0][sqcg_pkg::RS_W-1:0]  x_vec;
    sqcg_pkg::t_side                 x_sb;
    logic                            b_vld;
    logic [2:0][sqcg_pkg::VX_W-1:0]  b_res;
    logic                            b_zero;
    sqcg_pkg::t_side                 b_sb;
    sqcg_pkg::t_coord3               cor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_size   <= sqcg_pkg::HALF_SIZE_RST;
            r_normal_lift <= sqcg_pkg::NORMAL_LIFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqcg_pkg::REG_HALF_SIZE:   r_half_size   <= i_cfg_data;
                sqcg_pkg::REG_NORMAL_LIFT: r_normal_lift <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign v0 = {i_face.first_vertex_z, i_face.first_vertex_y, i_face.first_vertex_x};
    assign v1 = {i_face.second_vertex_z, i_face.second_vertex_y, i_face.second_vertex_x};
    assign nn = {i_face.normal_z, i_face.normal_y, i_face.normal_x};
    assign cc = {i_face.centre_z, i_face.centre_y, i_face.centre_x};
    assign i_face.ready = en;

    sqcg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_face.valid),
        .i_v0    (v0),
        .i_v1    (v1),
        .i_n     (nn),
        .i_c     (cc),
        .i_lift  (r_normal_lift),
        .o_vld   (f_vld),
        .o_vec   (f_vec),
        .o_sb    (f_sb)
    );

    sqcg_rescale u_edge_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_vec   (f_vec),
        .i_size  (r_half_size),
        .i_sb    (f_sb),
        .o_vld   (a_vld),
        .o_res   (a_res),
        .o_zero  (a_zero),
        .o_sb    (a_sb)
    );

    sqcg_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (a_vld),
        .i_vx    (a_res),
        .i_zero  (a_zero),
        .i_sb    (a_sb),
        .o_vld   (x_vld),
        .o_vec   (x_vec),
        .o_sb    (x_sb)
    );

    sqcg_rescale u_cross_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (x_vld),
        .i_vec   (x_vec),
        .i_size  (r_half_size),
        .i_sb    (x_sb),
        .o_vld   (b_vld),
        .o_res   (b_res),
        .o_zero  (b_zero),
        .o_sb    (b_sb)
    );

    sqcg_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (b_vld),
        .i_vy     (b_res),
        .i_zero   (b_zero),
        .i_sb     (b_sb),
        .i_ready  (o_corner.ready),
        .o_en     (en),
        .o_valid  (o_corner.valid),
        .o_index  (o_corner.corner_index),
        .o_corner (cor),
        .o_degen  (o_corner.degenerate),
        .o_last   (o_corner.last_corner)
    );

    assign o_corner.corner_x = cor[0];
    assign o_corner.corner_y = cor[1];
    assign o_corner.corner_z = cor[2];

endmodule

@@ verif/sqcg_checker.sv @@
// Corner predictor and scoreboard for the surface quad corner generator.
`timescale 1ns / 100ps
module sqcg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [sqcg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sqcg_pkg::REG_W-1:0]     i_cfg_data,
    sqcg_face_if.sink   face_mon,
    sqcg_corner_if.sink corner_mon,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]                           idx;
        logic signed [sqcg_pkg::COORD_W-1:0]  x;
        logic signed [sqcg_pkg::COORD_W-1:0]  y;
        logic signed [sqcg_pkg::COORD_W-1:0]  z;
        logic                                 degen;
        logic                                 last;
    } t_corner;

    typedef longint t_vec [3];

    t_corner                    corner_q [$];
    logic [sqcg_pkg::REG_W-1:0] size_reg;
    logic [sqcg_pkg::REG_W-1:0] lift_reg;

    assign o_pending = corner_q.size();

    function automatic longint unsigned magnitude(longint v);
        magnitude = (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        int_sqrt = res;
    endfunction

    function automatic bit scale_to_size(input t_vec v, input longint unsigned sz,
                                         output t_vec r);
        longint unsigned m [3];
        longint unsigned mx, len, q;
        for (int i = 0; i < 3; i++) m[i] = magnitude(v[i]);
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0) begin
            r = '{0, 0, 0};
            return 1'b1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * sz + (len >> 1)) / len;
            r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic logic [sqcg_pkg::COORD_W-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        clamp_coord = v[sqcg_pkg::COORD_W-1:0];
    endfunction

    task automatic predict_corners();
        t_vec    e, n, c, lf, vx, cr, vy;
        longint  d;
        longint unsigned p;
        bit      degen;
        t_corner k;
        e[0] = longint'(face_mon.second_vertex_x) - longint'(face_mon.first_vertex_x);
        e[1] = longint'(face_mon.second_vertex_y) - longint'(face_mon.first_vertex_y);
        e[2] = longint'(face_mon.second_vertex_z) - longint'(face_mon.first_vertex_z);
        n = '{longint'(face_mon.normal_x), longint'(face_mon.normal_y),
              longint'(face_mon.normal_z)};
        c = '{longint'(face_mon.centre_x), longint'(face_mon.centre_y),
              longint'(face_mon.centre_z)};
        for (int i = 0; i < 3; i++) begin
            p = (magnitude(n[i]) * lift_reg + (64'd1 << (sqcg_pkg::FRAC_BITS - 1)))
                >> sqcg_pkg::FRAC_BITS;
            lf[i] = (n[i] < 0) ? -longint'(p) : longint'(p);
        end
        degen = scale_to_size(e, size_reg, vx);
        cr[0] = vx[1] * n[2] - vx[2] * n[1];
        cr[1] = vx[2] * n[0] - vx[0] * n[2];
        cr[2] = vx[0] * n[1] - vx[1] * n[0];
        if (scale_to_size(cr, size_reg, vy)) degen = 1'b1;
        for (int j = 0; j < 4; j++) begin
            k.idx = j[1:0];
            for (int i = 0; i < 3; i++) begin
                unique case (j)
                    0: d = vx[i];
                    1: d = -vy[i];
                    2: d = -vx[i];
                    default: d = vy[i];
                endcase
                if (i == 0) k.x = clamp_coord(c[i] + d + lf[i]);
                else if (i == 1) k.y = clamp_coord(c[i] + d + lf[i]);
                else k.z = clamp_coord(c[i] + d + lf[i]);
            end
            k.degen = degen;
            k.last = (j == 3);
            corner_q.push_back(k);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_corner w;
        if (!i_rst_n) begin
            size_reg <= sqcg_pkg::HALF_SIZE_RST;
            lift_reg <= sqcg_pkg::NORMAL_LIFT_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sqcg_pkg::REG_HALF_SIZE:   size_reg <= i_cfg_data;
                    sqcg_pkg::REG_NORMAL_LIFT: lift_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (face_mon.valid && face_mon.ready) predict_corners();
            if (corner_mon.valid && corner_mon.ready) begin
                if (corner_q.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    w = corner_q.pop_front();
                    if (corner_mon.corner_index !== w.idx)
                        report_mismatch("corner_index", corner_mon.corner_index, w.idx);
                    if (corner_mon.corner_x !== w.x)
                        report_mismatch("corner_x", corner_mon.corner_x, w.x);
                    if (corner_mon.corner_y !== w.y)
                        report_mismatch("corner_y", corner_mon.corner_y, w.y);
                    if (corner_mon.corner_z !== w.z)
                        report_mismatch("corner_z", corner_mon.corner_z, w.z);
                    if (corner_mon.degenerate !== w.degen)
                        report_mismatch("degenerate", corner_mon.degenerate, w.degen);
                    if (corner_mon.last_corner !== w.last)
                        report_mismatch("last_corner", corner_mon.last_corner, w.last);
                end
            end
        end
    end
endmodule

@@ verif/testbench.sv @@
// Stimulus and verdict for the surface quad corner generator.
`timescale 1ns / 100ps
module testbench;

    localparam int LATENCY   = 115;
    localparam int CYCLE_CAP = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sqcg_pkg::CFG_IDX_W-1:0] i_cfg_idx = sqcg_pkg::REG_HALF_SIZE;
    logic [sqcg_pkg::REG_W-1:0]     i_cfg_data = '0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    sqcg_face_if   face ();
    sqcg_corner_if corner ();

    surface_quad_corner_generator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_face(face), .o_corner(corner)
    );

    sqcg_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .face_mon(face), .corner_mon(corner),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall per word
    initial begin
        int gap;
        corner.ready = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                corner.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            corner.ready <= 1'b1;
            do @(posedge i_clk); while (!corner.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_face(input logic [31:0] v0 [3], input logic [31:0] v1 [3],
                             input logic [sqcg_pkg::NORM_W-1:0] n [3],
                             input logic [31:0] c [3], input int gap);
        if (gap > 0) begin
            face.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        face.first_vertex_x <= v0[0]; face.first_vertex_y <= v0[1];
        face.first_vertex_z <= v0[2];
        face.second_vertex_x <= v1[0]; face.second_vertex_y <= v1[1];
        face.second_vertex_z <= v1[2];
        face.normal_x <= n[0]; face.normal_y <= n[1]; face.normal_z <= n[2];
        face.centre_x <= c[0]; face.centre_y <= c[1]; face.centre_z <= c[2];
        face.valid <= 1'b1;
        do @(posedge i_clk); while (!face.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: rand_coord = $urandom;
            1: rand_coord = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: rand_coord = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [sqcg_pkg::NORM_W-1:0] rand_norm();
        case ($urandom_range(0, 5))
            0: rand_norm = sqcg_pkg::NORM_W'(65536);
            1: rand_norm = sqcg_pkg::NORM_W'(-65536);
            2: rand_norm = '0;
            3: rand_norm = sqcg_pkg::NORM_W'($urandom);
            default: rand_norm = sqcg_pkg::NORM_W'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic random_face(input bit shared);
        logic [31:0] v0 [3], v1 [3], c [3];
        logic [sqcg_pkg::NORM_W-1:0] n [3];
        for (int i = 0; i < 3; i++) begin
            v0[i] = rand_coord();
            v1[i] = shared ? v0[i] : rand_coord();
            n[i]  = rand_norm();
            c[i]  = rand_coord();
        end
        if (!shared && $urandom_range(0, 7) == 0) v1 = v0;
        send_face(v0, v1, n, c, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    endtask

    task automatic drain();
        face.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sqcg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sqcg_pkg::REG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] v0 [3], v1 [3], c [3];
        logic [sqcg_pkg::NORM_W-1:0] n [3];
        logic [sqcg_pkg::REG_W-1:0] sizes [4];
        logic [sqcg_pkg::REG_W-1:0] lifts [4];
        face.valid = 1'b0;
        {face.first_vertex_x, face.first_vertex_y, face.first_vertex_z} = '0;
        {face.second_vertex_x, face.second_vertex_y, face.second_vertex_z} = '0;
        {face.normal_x, face.normal_y, face.normal_z} = '0;
        {face.centre_x, face.centre_y, face.centre_z} = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: unit edge, zero edge, parallel normal, zero normal, extremes, one-LSB edge
        v0 = '{0, 0, 0}; v1 = '{32'h10000, 0, 0};
        n = '{0, 0, sqcg_pkg::NORM_W'(65536)}; c = '{0, 0, 0};
        send_face(v0, v1, n, c, 0);
        send_face(v0, v0, n, c, 0);
        n = '{sqcg_pkg::NORM_W'(65536), 0, 0};
        send_face(v0, v1, n, c, 0);
        n = '{0, 0, 0};
        send_face(v0, v1, n, c, 2);
        v0 = '{32'h80000000, 32'h80000000, 32'h80000000};
        v1 = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        n = '{sqcg_pkg::NORM_W'(-65536), sqcg_pkg::NORM_W'(-65536),
              sqcg_pkg::NORM_W'(65536)};
        c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        send_face(v0, v1, n, c, 0);
        send_face(v1, v0, '{sqcg_pkg::NORM_W'(131071), sqcg_pkg::NORM_W'(-131072),
                            sqcg_pkg::NORM_W'(1)}, v0, 1);
        send_face('{0, 0, 0}, '{1, 0, 0}, '{0, sqcg_pkg::NORM_W'(65536), 0}, c, 0);
        drain();

        sizes = '{sqcg_pkg::REG_W'(65536), sqcg_pkg::REG_W'(0), sqcg_pkg::REG_W'(131071),
                  sqcg_pkg::REG_W'(6554)};
        lifts = '{sqcg_pkg::REG_W'(0), sqcg_pkg::REG_W'(65536), sqcg_pkg::REG_W'(131071),
                  sqcg_pkg::REG_W'(66)};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(sqcg_pkg::REG_HALF_SIZE, sizes[ph]);
            write_reg(sqcg_pkg::REG_NORMAL_LIFT, lifts[ph]);
            for (int k = 0; k < 75; k++) random_face($urandom_range(0, 15) == 0);
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/sqcg_pkg.sv
hw/rtl/sqcg_face_if.sv
hw/rtl/sqcg_corner_if.sv
hw/rtl/sqcg_front.sv
hw/rtl/sqcg_rescale.sv
hw/rtl/sqcg_cross.sv
hw/rtl/sqcg_emit.sv
hw/rtl/surface_quad_corner_generator_core.sv
verif/sqcg_checker.sv
verif/testbench.sv
